>>> rtl/core/rsch_pkg.sv
package rsch_pkg;

    localparam int MAX_BODIES_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QDEPTH         = 2;
    localparam int QAW            = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QLW            = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        KIND_RAY,
        KIND_BODY,
        KIND_SKIP
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               last;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic [30:0]        span;
        logic [10:0]        id;
    } item_t;

    typedef struct packed {
        logic           valid;
        logic [QLW-1:0] level;
    } q_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NSQ,
        ST_NSQRT,
        ST_NDIV_SET,
        ST_NDIV,
        ST_DOT,
        ST_PROJ,
        ST_PT,
        ST_OFF,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

>>> rtl/core/rsch_front.sv
module rsch_front #(
    parameter int MAX_BODIES = rsch_pkg::MAX_BODIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        s_tuser,
    input  logic              s_tlast,
    input  logic [239:0]      s_tdata,
    input  logic              pop,
    output rsch_pkg::item_t   head,
    output rsch_pkg::q_stat_t stat
);

    localparam int CW = $clog2(MAX_BODIES + 1);

    rsch_pkg::item_t q_reg [rsch_pkg::QDEPTH];
    logic [rsch_pkg::QAW-1:0] wr_ptr_reg;
    logic [rsch_pkg::QAW-1:0] rd_ptr_reg;
    logic [rsch_pkg::QLW-1:0] level_reg;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            cnt_next;
    rsch_pkg::item_t          item;
    logic                     push;

    assign s_tready = level_reg < rsch_pkg::QLW'(rsch_pkg::QDEPTH);
    assign push     = s_tvalid && s_tready;

    // classify the request and track bodies since the last ray
    always_comb begin
        cnt_next   = cnt_reg;
        item.last  = s_tlast;
        item.ax    = s_tdata[31:0];
        item.ay    = s_tdata[63:32];
        item.az    = s_tdata[95:64];
        item.bx    = s_tdata[127:96];
        item.by    = s_tdata[159:128];
        item.bz    = s_tdata[191:160];
        item.span  = s_tdata[222:192];
        item.id    = s_tdata[233:223];
        item.kind  = rsch_pkg::KIND_SKIP;
        if (!s_tuser[0]) begin
            item.kind = rsch_pkg::KIND_RAY;
            cnt_next  = '0;
        end else if (cnt_reg < CW'(MAX_BODIES)) begin
            cnt_next = cnt_reg + CW'(1);
            if (s_tuser[1]) begin
                item.kind = rsch_pkg::KIND_BODY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                q_reg[wr_ptr_reg] <= item;
                wr_ptr_reg        <= wr_ptr_reg + rsch_pkg::QAW'(1);
                cnt_reg           <= cnt_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + rsch_pkg::QAW'(1);
            end
            if (push && !pop) begin
                level_reg <= level_reg + rsch_pkg::QLW'(1);
            end else if (!push && pop) begin
                level_reg <= level_reg - rsch_pkg::QLW'(1);
            end
        end
    end

    assign head       = q_reg[rd_ptr_reg];
    assign stat.valid = level_reg != '0;
    assign stat.level = level_reg;

endmodule

>>> rtl/core/rsch_back.sv
module rsch_back #(
    parameter int FRAC_BITS = rsch_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rsch_pkg::item_t    head,
    input  rsch_pkg::q_stat_t  stat,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               o_hit,
    output logic [30:0]        o_dist,
    output logic signed [31:0] o_px,
    output logic signed [31:0] o_py,
    output logic signed [31:0] o_pz,
    output logic signed [17:0] o_nx,
    output logic signed [17:0] o_ny,
    output logic signed [17:0] o_nz,
    output logic [10:0]        o_body
);

    localparam int UW = FRAC_BITS + 2;
    localparam int NW = FRAC_BITS + 33;

    rsch_pkg::state_t state_reg, state_next;

    logic [2:0]  idx_reg;
    logic [5:0]  iter_reg;
    logic        last_reg;
    logic        nout_reg;
    logic signed [31:0] c_reg [3];
    logic [30:0] r_reg;
    logic [10:0] id_reg;
    logic signed [31:0] org_reg [3];
    logic signed [UW-1:0] unit_reg [3];
    logic [30:0] best_dist_reg;
    logic        found_reg;
    logic signed [31:0] bpt_reg [3];
    logic signed [31:0] boff_reg [3];
    logic [10:0] bbody_reg;
    logic signed [31:0] nv_reg [3];
    logic [63:0] sq_reg;
    logic [33:0] srem_reg;
    logic [31:0] root_reg;
    logic [32:0] drem_reg;
    logic [FRAC_BITS:0] dnum_reg;
    logic [FRAC_BITS:0] dq_reg;
    logic signed [UW-1:0] nres_reg [3];
    logic [30:0] proj_reg;
    logic signed [31:0] pt_reg [3];
    logic signed [31:0] off_reg [3];
    logic signed [63:0] acc_reg;
    logic signed [67:0] prod_reg;

    logic signed [33:0] mul_a, mul_b;
    logic [1:0]  sel, jsel;
    logic signed [63:0] acc_sum;
    logic [33:0] s_t, s_trial;
    logic        s_ge;
    logic [NW-1:0] d_n;
    logic [32:0] d_t;
    logic        d_ge;
    logic [FRAC_BITS:0] d_q;
    logic signed [UW-1:0] d_u;
    logic signed [63:0] proj;
    logic        proj_ok;
    logic signed [63:0] sdv;
    logic signed [33:0] pt34;
    logic signed [34:0] off35;
    logic [34:0] off_mag;
    logic        pt_fail;
    logic signed [31:0] pt_sat;
    logic        out_free;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    // round to nearest, ties away from zero
    function automatic logic signed [63:0] scale_down(input logic signed [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        m = v[63] ? 64'(-v) : 64'(v);
        r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    assign sel  = (idx_reg < 3'd3) ? idx_reg[1:0] : 2'd0;
    assign jsel = 2'(idx_reg - 3'd1);

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            rsch_pkg::ST_NSQ: begin
                mul_a = 34'(mag32(nv_reg[sel]));
                mul_b = 34'(mag32(nv_reg[sel]));
            end
            rsch_pkg::ST_DOT: begin
                mul_a = 34'(c_reg[sel]) - 34'(org_reg[sel]);
                mul_b = 34'(unit_reg[sel]);
            end
            rsch_pkg::ST_PT: begin
                mul_a = 34'(unit_reg[sel]);
                mul_b = {3'd0, proj_reg};
            end
            rsch_pkg::ST_OFF: begin
                if (idx_reg < 3'd3) begin
                    mul_a = 34'(mag32(off_reg[sel]));
                    mul_b = 34'(mag32(off_reg[sel]));
                end else begin
                    mul_a = {3'd0, r_reg};
                    mul_b = {3'd0, r_reg};
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign acc_sum = acc_reg + prod_reg[63:0];

    // square root digit step
    assign s_t     = {srem_reg[31:0], sq_reg[63:62]};
    assign s_trial = {root_reg, 2'b01};
    assign s_ge    = s_t >= s_trial;

    // divider step
    assign d_n  = {1'b0, mag32(nv_reg[sel]), FRAC_BITS'(0)} + NW'(root_reg >> 1);
    assign d_t  = {drem_reg[31:0], dnum_reg[FRAC_BITS]};
    assign d_ge = d_t >= {1'b0, root_reg};
    assign d_q  = {dq_reg[FRAC_BITS-1:0], d_ge};
    assign d_u  = (root_reg == '0) ? '0 :
                  (nv_reg[sel][31] ? -$signed(UW'(d_q)) : $signed(UW'(d_q)));

    // projection and closest point
    assign proj    = scale_down(acc_reg);
    assign proj_ok = (proj > 64'sd0) && (proj < $signed({33'd0, best_dist_reg}));
    assign sdv     = scale_down(prod_reg[63:0]);
    assign pt34    = 34'(org_reg[jsel]) + 34'(sdv);
    assign off35   = 35'(c_reg[jsel]) - 35'(pt34);
    assign off_mag = off35[34] ? 35'(-off35) : 35'(off35);
    assign pt_fail = off_mag > {4'd0, r_reg};
    assign pt_sat  = (pt34 > 34'sh07fffffff) ? 32'sh7fffffff :
                     (pt34 < -34'sh080000000) ? -32'sh80000000 : 32'(pt34);

    assign out_free = !m_valid || m_ready;
    assign pop      = (state_reg == rsch_pkg::ST_IDLE) && stat.valid;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rsch_pkg::ST_IDLE: begin
                if (stat.valid) begin
                    case (head.kind)
                        rsch_pkg::KIND_RAY:  state_next = rsch_pkg::ST_NSQ;
                        rsch_pkg::KIND_BODY: state_next = rsch_pkg::ST_DOT;
                        default:             state_next = rsch_pkg::ST_FIN;
                    endcase
                end
            end
            rsch_pkg::ST_NSQ: begin
                if (idx_reg == 3'd3) state_next = rsch_pkg::ST_NSQRT;
            end
            rsch_pkg::ST_NSQRT: begin
                if (iter_reg == 6'd31) state_next = rsch_pkg::ST_NDIV_SET;
            end
            rsch_pkg::ST_NDIV_SET: state_next = rsch_pkg::ST_NDIV;
            rsch_pkg::ST_NDIV: begin
                if (iter_reg == 6'(FRAC_BITS)) begin
                    if (idx_reg != 3'd2) begin
                        state_next = rsch_pkg::ST_NDIV_SET;
                    end else if (nout_reg) begin
                        state_next = rsch_pkg::ST_OUT;
                    end else begin
                        state_next = rsch_pkg::ST_FIN;
                    end
                end
            end
            rsch_pkg::ST_DOT: begin
                if (idx_reg == 3'd3) state_next = rsch_pkg::ST_PROJ;
            end
            rsch_pkg::ST_PROJ: begin
                state_next = proj_ok ? rsch_pkg::ST_PT : rsch_pkg::ST_FIN;
            end
            rsch_pkg::ST_PT: begin
                if (idx_reg != 3'd0 && pt_fail) begin
                    state_next = rsch_pkg::ST_FIN;
                end else if (idx_reg == 3'd3) begin
                    state_next = rsch_pkg::ST_OFF;
                end
            end
            rsch_pkg::ST_OFF: begin
                if (idx_reg == 3'd4) state_next = rsch_pkg::ST_FIN;
            end
            rsch_pkg::ST_FIN: begin
                if (!last_reg) begin
                    state_next = rsch_pkg::ST_IDLE;
                end else if (found_reg) begin
                    state_next = rsch_pkg::ST_NSQ;
                end else begin
                    state_next = rsch_pkg::ST_OUT;
                end
            end
            rsch_pkg::ST_OUT: begin
                if (out_free) state_next = rsch_pkg::ST_IDLE;
            end
            default: state_next = rsch_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsch_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            m_valid       <= 1'b0;
            found_reg     <= 1'b0;
            best_dist_reg <= '0;
            bbody_reg     <= '0;
            for (int i = 0; i < 3; i++) begin
                unit_reg[i] <= '0;
                org_reg[i]  <= '0;
            end
        end else begin
            if (m_valid && m_ready && state_reg != rsch_pkg::ST_OUT) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                rsch_pkg::ST_IDLE: begin
                    idx_reg  <= '0;
                    acc_reg  <= '0;
                    last_reg <= head.last;
                    c_reg[0] <= head.ax;
                    c_reg[1] <= head.ay;
                    c_reg[2] <= head.az;
                    r_reg    <= head.span;
                    id_reg   <= head.id;
                    if (stat.valid && head.kind == rsch_pkg::KIND_RAY) begin
                        org_reg[0]    <= head.ax;
                        org_reg[1]    <= head.ay;
                        org_reg[2]    <= head.az;
                        nv_reg[0]     <= head.bx;
                        nv_reg[1]     <= head.by;
                        nv_reg[2]     <= head.bz;
                        nout_reg      <= 1'b0;
                        best_dist_reg <= head.span;
                        found_reg     <= 1'b0;
                        bbody_reg     <= '0;
                    end
                end
                rsch_pkg::ST_NSQ: begin
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg != 3'd0) acc_reg <= acc_sum;
                    sq_reg   <= acc_sum;
                    srem_reg <= '0;
                    root_reg <= '0;
                    iter_reg <= '0;
                end
                rsch_pkg::ST_NSQRT: begin
                    iter_reg <= iter_reg + 6'd1;
                    sq_reg   <= {sq_reg[61:0], 2'b00};
                    idx_reg  <= '0;
                    if (s_ge) begin
                        srem_reg <= s_t - s_trial;
                        root_reg <= {root_reg[30:0], 1'b1};
                    end else begin
                        srem_reg <= s_t;
                        root_reg <= {root_reg[30:0], 1'b0};
                    end
                end
                rsch_pkg::ST_NDIV_SET: begin
                    drem_reg <= {1'b0, d_n[NW-1:FRAC_BITS+1]};
                    dnum_reg <= d_n[FRAC_BITS:0];
                    dq_reg   <= '0;
                    iter_reg <= '0;
                end
                rsch_pkg::ST_NDIV: begin
                    iter_reg <= iter_reg + 6'd1;
                    dnum_reg <= {dnum_reg[FRAC_BITS-1:0], 1'b0};
                    dq_reg   <= d_q;
                    drem_reg <= d_ge ? (d_t - {1'b0, root_reg}) : d_t;
                    if (iter_reg == 6'(FRAC_BITS)) begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd2) begin
                            nres_reg[0] <= nres_reg[0];
                            for (int i = 0; i < 2; i++) begin
                                if (!nout_reg) unit_reg[i] <= nres_reg[i];
                            end
                            if (!nout_reg) unit_reg[2] <= d_u;
                            nres_reg[2] <= d_u;
                        end else begin
                            nres_reg[sel] <= d_u;
                        end
                    end
                end
                rsch_pkg::ST_DOT: begin
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg != 3'd0) acc_reg <= acc_sum;
                end
                rsch_pkg::ST_PROJ: begin
                    proj_reg <= proj[30:0];
                    idx_reg  <= '0;
                end
                rsch_pkg::ST_PT: begin
                    acc_reg <= '0;
                    if (idx_reg != 3'd0) begin
                        pt_reg[jsel]  <= pt_sat;
                        off_reg[jsel] <= 32'(off35);
                    end
                    if (idx_reg == 3'd3) begin
                        idx_reg <= '0;
                    end else begin
                        idx_reg <= idx_reg + 3'd1;
                    end
                end
                rsch_pkg::ST_OFF: begin
                    idx_reg <= idx_reg + 3'd1;
                    if (idx_reg != 3'd0 && idx_reg != 3'd4) acc_reg <= acc_sum;
                    if (idx_reg == 3'd4 && !($unsigned(acc_reg) > prod_reg[63:0])) begin
                        best_dist_reg <= proj_reg;
                        found_reg     <= 1'b1;
                        bbody_reg     <= id_reg;
                        for (int i = 0; i < 3; i++) begin
                            bpt_reg[i]  <= pt_reg[i];
                            boff_reg[i] <= off_reg[i];
                        end
                    end
                end
                rsch_pkg::ST_FIN: begin
                    idx_reg  <= '0;
                    acc_reg  <= '0;
                    nout_reg <= 1'b1;
                    for (int i = 0; i < 3; i++) begin
                        nv_reg[i] <= boff_reg[i];
                    end
                end
                rsch_pkg::ST_OUT: begin
                    if (out_free) begin
                        m_valid <= 1'b1;
                        o_hit   <= found_reg;
                        o_dist  <= found_reg ? best_dist_reg : '0;
                        o_px    <= found_reg ? bpt_reg[0] : '0;
                        o_py    <= found_reg ? bpt_reg[1] : '0;
                        o_pz    <= found_reg ? bpt_reg[2] : '0;
                        o_nx    <= found_reg ? 18'(nres_reg[0]) : '0;
                        o_ny    <= found_reg ? 18'(nres_reg[1]) : '0;
                        o_nz    <= found_reg ? 18'(nres_reg[2]) : '0;
                        o_body  <= found_reg ? bbody_reg : '0;
                    end
                end
                default: begin
                    idx_reg <= '0;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/ray_sphere_closest_hit.sv
// Nearest ray/sphere hit in Q(FRAC_BITS) fixed point. A ray request (tuser[0] = 0) loads the
// origin, normalizes the direction and sets the range; each body request (tuser[0] = 1,
// tuser[1] = sphere) is tested against the current ray, and a request with tlast set gives
// one result. Requests enter a two-deep queue, so the input keeps taking requests, until the
// queue is full, while the back end works and while a result waits at the output register.
// Requests share one 34x34 multiplier; a ray also runs a bit-serial square root and a
// bit-serial divider, and a result with a hit adds one more normalization of the normal.
module ray_sphere_closest_hit #(
    parameter int MAX_BODIES = rsch_pkg::MAX_BODIES_DEF,
    parameter int FRAC_BITS  = rsch_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, span, body_id, zero pad
    input  logic [239:0] s_tdata,
    // action, is_sphere
    input  logic [1:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_distance, point_x, point_y, point_z, normal_x, normal_y, normal_z, hit_body
    output logic [191:0] m_tdata,
    // hit
    output logic [0:0]   m_tuser
);

    rsch_pkg::item_t   head;
    rsch_pkg::q_stat_t q_stat;
    logic              pop;
    logic              o_hit;
    logic [30:0]       o_dist;
    logic signed [31:0] o_px, o_py, o_pz;
    logic signed [17:0] o_nx, o_ny, o_nz;
    logic [10:0]       o_body;

    rsch_front #(.MAX_BODIES(MAX_BODIES)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tdata  (s_tdata),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    rsch_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .stat    (q_stat),
        .pop     (pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .o_hit   (o_hit),
        .o_dist  (o_dist),
        .o_px    (o_px),
        .o_py    (o_py),
        .o_pz    (o_pz),
        .o_nx    (o_nx),
        .o_ny    (o_ny),
        .o_nz    (o_nz),
        .o_body  (o_body)
    );

    assign m_tdata = {o_body, o_nz, o_ny, o_nx, o_pz, o_py, o_px, o_dist};
    assign m_tuser = o_hit;

    a_nohit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss result carries nonzero fields");

    a_hit_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[30:0] != '0)
        else $error("hit with zero distance");

    a_queue_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !pop |=> q_stat.level == $past(q_stat.level) + 1'b1)
        else $error("queue level lost a request");

endmodule

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit ACT_RAY   = 1'b0;
    localparam bit ACT_BODY  = 1'b1;
    localparam int NUM_ITEMS = 1950;
    localparam int MAX_BODY_CNT = rsch_pkg::MAX_BODIES_DEF;
    localparam int FB = rsch_pkg::FRAC_BITS_DEF;

    class hit_scoreboard;
        longint org[3], udir[3], max_dist, best_dist;
        bit found;
        longint best_pt[3], best_off[3];
        int best_id;
        int body_cnt;
        logic [192:0] hit_q[$];
        int errors;

        function void report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint round_down(longint v);
            longint r;
            r = (mag(v) + (64'd1 << (FB - 1))) >> FB;
            return (v < 0) ? -r : r;
        endfunction

        function void to_unit(input longint v[3], output longint u[3]);
            longint unsigned s, len, m;
            s = 0;
            for (int i = 0; i < 3; i++) begin
                m = mag(v[i]);
                s += m * m;
            end
            len = root(s);
            for (int i = 0; i < 3; i++) begin
                if (len == 0) begin
                    u[i] = 0;
                end else begin
                    m = ((mag(v[i]) << FB) + (len >> 1)) / len;
                    u[i] = (v[i] < 0) ? -longint'(m) : longint'(m);
                end
            end
        endfunction

        function void try_sphere(longint c[3], longint rad, int id);
            longint dot, proj;
            longint pt[3], off[3];
            longint unsigned s;
            dot = 0;
            for (int i = 0; i < 3; i++) dot += (c[i] - org[i]) * udir[i];
            proj = round_down(dot);
            if (!(proj > 0 && proj < max_dist && proj < best_dist)) return;
            for (int i = 0; i < 3; i++) begin
                pt[i] = org[i] + round_down(udir[i] * proj);
                off[i] = c[i] - pt[i];
                if (mag(off[i]) > rad) return;
            end
            s = 0;
            for (int i = 0; i < 3; i++) s += longint'(mag(off[i])) * mag(off[i]);
            if (s > longint'(rad) * rad) return;
            best_dist = proj;
            found = 1;
            for (int i = 0; i < 3; i++) begin
                best_pt[i] = (pt[i] > 64'sd2147483647) ? 64'sd2147483647 :
                             (pt[i] < -64'sd2147483648) ? -64'sd2147483648 : pt[i];
                best_off[i] = off[i];
            end
            best_id = id;
        endfunction

        function void note_request(logic [239:0] d, logic [1:0] u, logic l);
            longint a[3], b[3], n[3];
            longint span;
            logic [192:0] e;
            for (int i = 0; i < 3; i++) begin
                a[i] = longint'($signed(d[32*i +: 32]));
                b[i] = longint'($signed(d[96 + 32*i +: 32]));
            end
            span = longint'(d[222:192]);
            if (u[0] == ACT_RAY) begin
                org = a;
                to_unit(b, udir);
                max_dist = span;
                best_dist = span;
                found = 0;
                best_id = 0;
                body_cnt = 0;
                for (int i = 0; i < 3; i++) begin
                    best_pt[i] = 0;
                    best_off[i] = 0;
                end
            end else if (body_cnt < MAX_BODY_CNT) begin
                body_cnt++;
                if (u[1]) try_sphere(a, span, int'(d[233:223]));
            end
            if (!l) return;
            e = '0;
            if (found) begin
                to_unit(best_off, n);
                e[192] = 1'b1;
                e[30:0] = best_dist[30:0];
                for (int i = 0; i < 3; i++) begin
                    e[31 + 32*i +: 32] = best_pt[i][31:0];
                    e[127 + 18*i +: 18] = n[i][17:0];
                end
                e[191:181] = best_id[10:0];
            end
            hit_q.push_back(e);
        endfunction

        function void check_result(logic [191:0] d, logic [0:0] u);
            logic [192:0] e;
            if (hit_q.size() == 0) begin
                $display("unexpected result");
                errors++;
                return;
            end
            e = hit_q.pop_front();
            if (u[0] !== e[192]) report("hit", u[0], e[192]);
            if (d[30:0] !== e[30:0]) report("hit_distance", d[30:0], e[30:0]);
            for (int i = 0; i < 3; i++) begin
                if (d[31 + 32*i +: 32] !== e[31 + 32*i +: 32])
                    report($sformatf("point[%0d]", i), $signed(d[31 + 32*i +: 32]),
                           $signed(e[31 + 32*i +: 32]));
                if (d[127 + 18*i +: 18] !== e[127 + 18*i +: 18])
                    report($sformatf("normal[%0d]", i), $signed(d[127 + 18*i +: 18]),
                           $signed(e[127 + 18*i +: 18]));
            end
            if (d[191:181] !== e[191:181]) report("hit_body", d[191:181], e[191:181]);
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [239:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [191:0] m_tdata;
    logic [0:0]   m_tuser;

    hit_scoreboard sb = new();
    int  sent;
    bit  calm;

    ray_sphere_closest_hit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_request(s_tdata, s_tuser, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // result side stalls
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send(bit act, bit sph, bit lst, longint a[3], longint b[3],
                        longint span, int id);
        int gap;
        logic [239:0] d;
        d = '0;
        for (int i = 0; i < 3; i++) begin
            d[32*i +: 32] = a[i][31:0];
            d[96 + 32*i +: 32] = b[i][31:0];
        end
        d[222:192] = span[30:0];
        d[233:223] = id[10:0];
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= {sph, act};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    function automatic longint rnd32();
        return longint'($signed($urandom()));
    endfunction

    task automatic random_query(int nbody);
        longint o[3], dv[3], c[3], z[3];
        longint span, t, noise;
        real len;
        int mode;
        z = '{0, 0, 0};
        for (int i = 0; i < 3; i++) begin
            o[i] = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
            dv[i] = ($urandom_range(0, 3) == 0) ? 0 :
                    longint'($urandom_range(0, 1 << 18)) - (1 << 17);
        end
        if ($urandom_range(0, 40) == 0) dv = z;
        mode = $urandom_range(0, 19);
        span = (mode == 0) ? 0 : (mode == 1) ? longint'($urandom() >> 1) :
               longint'($urandom_range(1, 1 << 26));
        send(ACT_RAY, 1'($urandom_range(0, 1)), nbody == 0, o, dv, span,
             $urandom_range(0, 2047));
        len = $sqrt(real'(dv[0]) * dv[0] + real'(dv[1]) * dv[1] + real'(dv[2]) * dv[2]);
        for (int k = 0; k < nbody; k++) begin
            t = longint'($urandom_range(0, 1 << 25)) - 1024;
            noise = longint'($urandom_range(0, 1 << $urandom_range(0, 18)));
            for (int i = 0; i < 3; i++) begin
                c[i] = o[i] + ((len > 0) ? longint'($rtoi(dv[i] / len * t)) : 0) +
                       longint'($urandom_range(0, 2 * noise)) - noise;
                if ($urandom_range(0, 15) == 0) c[i] = rnd32();
            end
            send(ACT_BODY, $urandom_range(0, 9) != 0, k == nbody - 1, c, dv,
                 ($urandom_range(0, 15) == 0) ? longint'($urandom() >> 1) :
                 noise * longint'($urandom_range(1, 3)) + longint'($urandom_range(0, 3)),
                 $urandom_range(0, 2047));
        end
    endtask

    initial begin
        longint z[3], big[3], lo[3], c[3], dx[3];
        int limit;
        z = '{0, 0, 0};
        big = '{64'sd2147483647, 64'sd2147483647, 64'sd2147483647};
        lo = '{-64'sd2147483648, -64'sd2147483648, -64'sd2147483648};
        dx = '{64'sd65536, 0, 0};
        calm = 1'b0;
        sent = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bodies before any ray
        send(ACT_BODY, 1, 0, '{64'sd100000, 0, 0}, z, 64'sd65536, 5);
        send(ACT_BODY, 1, 1, big, big, 64'sd2147483647, 2047);
        // last on a ray, zero direction
        send(ACT_RAY, 0, 1, z, z, 64'sd2147483647, 0);
        // simple hits along x, nearest kept, non-sphere skipped, id extremes
        send(ACT_RAY, 0, 0, z, '{64'sd3, 0, 0}, 64'sd2147483647, 0);
        c = '{64'sd655360, 64'sd1000, 0};
        send(ACT_BODY, 1, 0, c, z, 64'sd65536, 2047);
        c = '{64'sd327680, -64'sd5000, 64'sd7};
        send(ACT_BODY, 1, 0, c, z, 64'sd65536, 0);
        c = '{64'sd65536, 0, 0};
        send(ACT_BODY, 0, 0, c, z, 64'sd65536, 9);
        c = '{-64'sd327680, 0, 0};
        send(ACT_BODY, 1, 1, c, z, 64'sd2147483647, 1);
        // bodies after last keep accumulating
        send(ACT_BODY, 1, 1, '{64'sd131072, 0, 64'sd100}, z, 64'sd200, 1024);
        // zero span on a ray
        send(ACT_RAY, 1, 0, z, dx, 0, 3);
        send(ACT_BODY, 1, 1, '{64'sd65536, 0, 0}, z, 64'sd2147483647, 4);
        // extreme origins and directions
        send(ACT_RAY, 0, 0, lo, big, 64'sd2147483647, 2047);
        send(ACT_BODY, 1, 0, big, lo, 64'sd2147483647, 2047);
        send(ACT_BODY, 1, 1, z, big, 64'sd2147483647, 7);
        send(ACT_RAY, 0, 0, big, lo, 64'sd2147483647, 0);
        send(ACT_BODY, 1, 0, lo, z, 64'sd2147483647, 1000);
        send(ACT_BODY, 1, 1, z, z, 64'sd2147483647, 12);
        send(ACT_RAY, 0, 0, z, '{-64'sd1, -64'sd1, -64'sd1}, 64'sd2147483647, 0);
        send(ACT_BODY, 1, 1, '{-64'sd1000000, -64'sd1000000, -64'sd999000}, z,
             64'sd2147483647, 77);

        // too many bodies in one query
        send(ACT_RAY, 0, 0, z, dx, 64'sd2147483647, 0);
        for (int k = 0; k < MAX_BODY_CNT + 6; k++) begin
            if (k % 200 == 0) calm = ~calm;
            c = '{longint'(MAX_BODY_CNT + 10 - k) * 1000, 0, 0};
            send(ACT_BODY, (k % 97 == 0) || k > MAX_BODY_CNT - 3, k == MAX_BODY_CNT + 5,
                 c, z, 64'sd500, k);
        end
        calm = 1'b0;

        while (sent < NUM_ITEMS) begin
            if ($urandom_range(0, 7) == 0) calm = ~calm;
            if ($urandom_range(0, 9) == 0) begin
                send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)),
                     '{rnd32(), rnd32(), rnd32()}, '{rnd32(), rnd32(), rnd32()},
                     longint'($urandom() >> 1), $urandom_range(0, 2047));
            end else begin
                random_query($urandom_range(0, 8));
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        limit = 0;
        while (sb.hit_q.size() != 0 && limit < 100000) begin
            @(posedge aclk);
            limit++;
        end
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.hit_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rsch_pkg.sv
rtl/core/rsch_front.sv
rtl/core/rsch_back.sv
rtl/core/ray_sphere_closest_hit.sv
dv/tb_top.sv
